[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line rasterizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/clr_pkg.sv]
// ---------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, register indices, command codes and control structs.
// ---------------------------------------------------------------------------
package clr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned IMG_BITS       = 13;
  localparam int unsigned CLIP_POS_BITS  = 13;
  localparam int unsigned CLIP_SIZE_BITS = 14;
  localparam int unsigned ADDR_BITS      = 24;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 14;

  localparam logic [IMG_BITS-1:0] IMG_SIZE_RESET = 13'd4096;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CLIP_ENABLE  = 3'd2,
    REG_CLIP_LEFT    = 3'd3,
    REG_CLIP_TOP     = 3'd4,
    REG_CLIP_WIDTH   = 3'd5,
    REG_CLIP_HEIGHT  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    logic accept;
    logic x_major;
    logic neg_x;
    logic neg_y;
  } setup_flags_t;

  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

  // working width for clip and bounding-box arithmetic
  function automatic int unsigned clr_work_bits(input int unsigned coord_bits);
    int unsigned cw;
    cw = coord_bits + 1;
    return ((cw > CLIP_SIZE_BITS) ? cw : CLIP_SIZE_BITS) + 3;
  endfunction

endpackage

[rtl/clipped_line_rasterizer_top.sv]
// ---------------------------------------------------------------------------
// Clipped line rasterizer
// Midpoint line walk with clip window trimming; one point per step
// transaction, with pixel address, inside-clip and last-point flags.
//
//   channel  direction  handshake                  payload
//   in_      input      in_valid / in_stall        action, endpoints
//   out_     output     out_valid / out_stall      point, flags, address
//   cfg_     input      cfg_valid / cfg_ready      register index, data
//
// A transaction is held in the input register until it is resolved, and a step
// result is then written into the output register.
// Sustained rate is one transaction per cycle while out_stall is low, set by the walk
// update and the 12x13 address multiplier feeding the output register.
// Synchronous active-low reset clears the active line and both valid flags.
// out_stall holds the output register; a step behind it then stalls in_.
// Start transactions never wait on out_stall. cfg_ready is always high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_line_rasterizer_top #(
  parameter int unsigned COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic                                       in_action,
  input  logic signed [COORD_BITS:0]                 in_start_x,
  input  logic signed [COORD_BITS:0]                 in_start_y,
  input  logic signed [COORD_BITS:0]                 in_end_x,
  input  logic signed [COORD_BITS:0]                 in_end_y,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [COORD_BITS:0]                 out_point_x,
  output logic signed [COORD_BITS:0]                 out_point_y,
  output logic                                       out_inside_clip,
  output logic        [clr_pkg::ADDR_BITS-1:0]       out_pixel_address,
  output logic                                       out_last_point,
  output logic                                       out_no_point,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic        [clr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic        [clr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import clr_pkg::*;

  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned WW = clr_work_bits(COORD_BITS);
  localparam int unsigned DW = CW + 4;

  // configuration
  logic        [IMG_BITS-1:0]       image_width_r, image_height_r;
  logic                             clip_enable_r;
  logic signed [CLIP_POS_BITS-1:0]  clip_left_r, clip_top_r;
  logic signed [CLIP_SIZE_BITS-1:0] clip_width_r, clip_height_r;

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  action_t              s1_action_r;
  logic signed [CW-1:0] s1_start_x_r, s1_start_y_r, s1_end_x_r, s1_end_y_r;

  logic                 in_acc, out_free, s1_start, s1_fire;
  logic                 out_valid_r, out_valid_nxt;
  walk_ctrl_t           ctrl;

  setup_flags_t         flags;
  logic signed [WW-1:0] clip_x0, clip_x1, clip_y0, clip_y1;
  logic        [CW:0]   twice_dx, twice_dy;
  logic signed [DW-1:0] decision;
  logic signed [CW-1:0] stop_coord;

  logic signed [CW-1:0]    w_point_x, w_point_y;
  logic                    w_inside, w_last, w_no_point;
  logic [ADDR_BITS-1:0]    w_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMG_SIZE_RESET;
      image_height_r <= IMG_SIZE_RESET;
      clip_enable_r  <= 1'b0;
      clip_left_r    <= '0;
      clip_top_r     <= '0;
      clip_width_r   <= '0;
      clip_height_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[IMG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[IMG_BITS-1:0];
        REG_CLIP_ENABLE:  clip_enable_r  <= cfg_data[0];
        REG_CLIP_LEFT:    clip_left_r    <= $signed(cfg_data[CLIP_POS_BITS-1:0]);
        REG_CLIP_TOP:     clip_top_r     <= $signed(cfg_data[CLIP_POS_BITS-1:0]);
        REG_CLIP_WIDTH:   clip_width_r   <= $signed(cfg_data[CLIP_SIZE_BITS-1:0]);
        REG_CLIP_HEIGHT:  clip_height_r  <= $signed(cfg_data[CLIP_SIZE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // flow control
  assign s1_start  = (s1_action_r == ACT_START);
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (s1_start || out_free);
  assign in_stall  = s1_valid_r && !(s1_start || out_free);
  assign in_acc    = in_valid && !in_stall;
  assign ctrl.load = s1_fire && s1_start;
  assign ctrl.step = s1_fire && !s1_start;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r  <= action_t'(in_action);
      s1_start_x_r <= in_start_x;
      s1_start_y_r <= in_start_y;
      s1_end_x_r   <= in_end_x;
      s1_end_y_r   <= in_end_y;
    end
  end

  clr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x      (s1_start_x_r),
    .start_y      (s1_start_y_r),
    .end_x        (s1_end_x_r),
    .end_y        (s1_end_y_r),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .clip_enable  (clip_enable_r),
    .clip_left    (clip_left_r),
    .clip_top     (clip_top_r),
    .clip_width   (clip_width_r),
    .clip_height  (clip_height_r),
    .flags        (flags),
    .clip_x0      (clip_x0),
    .clip_x1      (clip_x1),
    .clip_y0      (clip_y0),
    .clip_y1      (clip_y1),
    .twice_dx     (twice_dx),
    .twice_dy     (twice_dy),
    .decision     (decision),
    .stop_coord   (stop_coord)
  );

  clr_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .flags         (flags),
    .start_x       (s1_start_x_r),
    .start_y       (s1_start_y_r),
    .clip_x0       (clip_x0),
    .clip_x1       (clip_x1),
    .clip_y0       (clip_y0),
    .clip_y1       (clip_y1),
    .twice_dx      (twice_dx),
    .twice_dy      (twice_dy),
    .decision      (decision),
    .stop_coord    (stop_coord),
    .image_width   (image_width_r),
    .point_x       (w_point_x),
    .point_y       (w_point_y),
    .inside_clip   (w_inside),
    .pixel_address (w_addr),
    .last_point    (w_last),
    .no_point      (w_no_point)
  );

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      out_point_x       <= w_point_x;
      out_point_y       <= w_point_y;
      out_inside_clip   <= w_inside;
      out_pixel_address <= w_addr;
      out_last_point    <= w_last;
      out_no_point      <= w_no_point;
    end
  end

  assign out_valid = out_valid_r;

  `CLR_ASSERT_IMPLY(a_no_point_clean, clk, rst_n,
    out_valid_r && out_no_point,
    !out_inside_clip && !out_last_point && (out_pixel_address == '0),
    "no_point transaction carries point data")
  `CLR_ASSERT_IMPLY(a_addr_outside_zero, clk, rst_n,
    out_valid_r && !out_inside_clip, out_pixel_address == '0,
    "pixel address set for a point outside the clip window")
  `CLR_ASSERT_NEXT(a_start_no_result, clk, rst_n,
    ctrl.load, out_valid_r == $past(out_valid_r && out_stall),
    "start transaction produced a result")
  `CLR_ASSERT_NEXT(a_last_ends_line, clk, rst_n,
    ctrl.step && w_last, w_no_point,
    "line still active after its last point")

endmodule

[rtl/clr_setup.sv]
// ---------------------------------------------------------------------------
// Line setup
// Derives deltas, walk direction, initial decision and the trimmed clip
// window from a start transaction; flags lines that are rejected outright.
// ---------------------------------------------------------------------------
module clr_setup #(
  parameter int unsigned COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS:0]                 start_x,
  input  logic signed [COORD_BITS:0]                 start_y,
  input  logic signed [COORD_BITS:0]                 end_x,
  input  logic signed [COORD_BITS:0]                 end_y,
  input  logic        [clr_pkg::IMG_BITS-1:0]        image_width,
  input  logic        [clr_pkg::IMG_BITS-1:0]        image_height,
  input  logic                                       clip_enable,
  input  logic signed [clr_pkg::CLIP_POS_BITS-1:0]   clip_left,
  input  logic signed [clr_pkg::CLIP_POS_BITS-1:0]   clip_top,
  input  logic signed [clr_pkg::CLIP_SIZE_BITS-1:0]  clip_width,
  input  logic signed [clr_pkg::CLIP_SIZE_BITS-1:0]  clip_height,
  output clr_pkg::setup_flags_t                      flags,
  output logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_x0,
  output logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_x1,
  output logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_y0,
  output logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_y1,
  output logic        [COORD_BITS+1:0]               twice_dx,
  output logic        [COORD_BITS+1:0]               twice_dy,
  output logic signed [COORD_BITS+4:0]               decision,
  output logic signed [COORD_BITS:0]                 stop_coord
);
  import clr_pkg::*;

  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned WW = clr_work_bits(COORD_BITS);

  logic signed [WW-1:0] x1, y1, x2, y2, dx, dy, adx_s, ady_s;
  logic signed [WW-1:0] bx_min, bx_max, by_min, by_max;
  logic signed [WW-1:0] iw, ih, cl, ct, cwd, chd;
  logic signed [WW-1:0] ex, ey, ew, eh;
  logic        [CW-1:0] adx, ady;
  logic                 x_major, zero_len, empty, box_hit;

  assign x1 = $signed({{(WW-CW){start_x[CW-1]}}, start_x});
  assign y1 = $signed({{(WW-CW){start_y[CW-1]}}, start_y});
  assign x2 = $signed({{(WW-CW){end_x[CW-1]}}, end_x});
  assign y2 = $signed({{(WW-CW){end_y[CW-1]}}, end_y});

  assign dx    = x2 - x1;
  assign dy    = y2 - y1;
  assign adx_s = dx[WW-1] ? -dx : dx;
  assign ady_s = dy[WW-1] ? -dy : dy;
  assign adx   = adx_s[CW-1:0];
  assign ady   = ady_s[CW-1:0];

  assign twice_dx = {adx, 1'b0};
  assign twice_dy = {ady, 1'b0};
  assign x_major  = adx > ady;

  assign decision = x_major ? ($signed({3'b000, twice_dy}) - $signed({4'b0000, adx}))
                            : ($signed({3'b000, twice_dx}) - $signed({4'b0000, ady}));
  assign stop_coord = x_major ? end_x : end_y;

  assign bx_min = (x1 < x2) ? x1 : x2;
  assign bx_max = (x1 < x2) ? x2 : x1;
  assign by_min = (y1 < y2) ? y1 : y2;
  assign by_max = (y1 < y2) ? y2 : y1;

  assign iw  = $signed({{(WW-IMG_BITS){1'b0}}, image_width});
  assign ih  = $signed({{(WW-IMG_BITS){1'b0}}, image_height});
  assign cl  = $signed({{(WW-CLIP_POS_BITS){clip_left[CLIP_POS_BITS-1]}}, clip_left});
  assign ct  = $signed({{(WW-CLIP_POS_BITS){clip_top[CLIP_POS_BITS-1]}}, clip_top});
  assign cwd = $signed({{(WW-CLIP_SIZE_BITS){clip_width[CLIP_SIZE_BITS-1]}}, clip_width});
  assign chd = $signed({{(WW-CLIP_SIZE_BITS){clip_height[CLIP_SIZE_BITS-1]}}, clip_height});

  // trim the clip window to the image; the whole image when clipping is off
  always_comb begin
    ex = '0;
    ey = '0;
    ew = iw;
    eh = ih;
    if (clip_enable) begin
      ex = cl;
      ey = ct;
      ew = cwd;
      eh = chd;
      if (ex[WW-1]) begin
        ew = ew + ex;
        ex = '0;
      end
      if (ey[WW-1]) begin
        eh = eh + ey;
        ey = '0;
      end
      if (ex + ew > iw) begin
        ew = iw - ex;
      end
      if (ey + eh > ih) begin
        eh = ih - ey;
      end
    end
  end

  assign clip_x0 = ex;
  assign clip_y0 = ey;
  assign clip_x1 = ex + ew;
  assign clip_y1 = ey + eh;

  assign zero_len = (dx == '0) && (dy == '0);
  assign empty    = ew[WW-1] || (ew == '0) || eh[WW-1] || (eh == '0);
  assign box_hit  = (ex <= bx_max) && (ey <= by_max) && (bx_min < clip_x1) && (by_min < clip_y1);

  assign flags.accept  = !zero_len && !empty && box_hit;
  assign flags.x_major = x_major;
  assign flags.neg_x   = dx[WW-1];
  assign flags.neg_y   = dy[WW-1];

endmodule

[rtl/clr_walk.sv]
// ---------------------------------------------------------------------------
// Line walker
// Holds the midpoint walk state, forms the current point with its clip
// flag and pixel address, and advances one step per step transaction until the last point.
// ---------------------------------------------------------------------------
module clr_walk #(
  parameter int unsigned COORD_BITS = clr_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  clr_pkg::walk_ctrl_t                        ctrl,
  input  clr_pkg::setup_flags_t                      flags,
  input  logic signed [COORD_BITS:0]                 start_x,
  input  logic signed [COORD_BITS:0]                 start_y,
  input  logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_x0,
  input  logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_x1,
  input  logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_y0,
  input  logic signed [clr_pkg::clr_work_bits(COORD_BITS)-1:0] clip_y1,
  input  logic        [COORD_BITS+1:0]               twice_dx,
  input  logic        [COORD_BITS+1:0]               twice_dy,
  input  logic signed [COORD_BITS+4:0]               decision,
  input  logic signed [COORD_BITS:0]                 stop_coord,
  input  logic        [clr_pkg::IMG_BITS-1:0]        image_width,
  output logic signed [COORD_BITS:0]                 point_x,
  output logic signed [COORD_BITS:0]                 point_y,
  output logic                                       inside_clip,
  output logic        [clr_pkg::ADDR_BITS-1:0]       pixel_address,
  output logic                                       last_point,
  output logic                                       no_point
);
  import clr_pkg::*;

  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned WW = clr_work_bits(COORD_BITS);
  localparam int unsigned DW = CW + 4;
  localparam int unsigned PW = CW - 1 + IMG_BITS;

  logic                 active_r;
  logic signed [CW-1:0] cur_x_r, cur_y_r, stop_r;
  logic signed [DW-1:0] dec_r;
  logic        [CW:0]   tdx_r, tdy_r;
  logic                 x_major_r, neg_x_r, neg_y_r;
  logic signed [WW-1:0] cx0_r, cx1_r, cy0_r, cy1_r;

  logic signed [WW-1:0] cur_x_w, cur_y_w;
  logic signed [CW-1:0] cur_x_nxt, cur_y_nxt;
  logic signed [DW-1:0] dec_nxt, dec_add, dec_sub;
  logic                 dec_pos, hit, at_end;
  logic        [PW-1:0] product;
  logic        [PW:0]   addr_sum;

  assign cur_x_w = $signed({{(WW-CW){cur_x_r[CW-1]}}, cur_x_r});
  assign cur_y_w = $signed({{(WW-CW){cur_y_r[CW-1]}}, cur_y_r});

  assign hit = (cur_x_w >= cx0_r) && (cur_x_w < cx1_r) &&
               (cur_y_w >= cy0_r) && (cur_y_w < cy1_r);
  assign at_end = x_major_r ? (cur_x_r == stop_r) : (cur_y_r == stop_r);

  // clip window starts at zero or above, so a hit point is non-negative
  assign product  = cur_y_r[CW-2:0] * image_width;
  assign addr_sum = {1'b0, product} + {{(PW-CW+2){1'b0}}, cur_x_r[CW-2:0]};

  assign no_point      = !active_r;
  assign point_x       = active_r ? cur_x_r : '0;
  assign point_y       = active_r ? cur_y_r : '0;
  assign inside_clip   = active_r && hit;
  assign pixel_address = (active_r && hit) ? ADDR_BITS'(addr_sum) : '0;
  assign last_point    = active_r && at_end;

  assign dec_pos   = !dec_r[DW-1];
  assign cur_x_nxt = (x_major_r || dec_pos) ? (neg_x_r ? cur_x_r - CW'(1) : cur_x_r + CW'(1))
                                            : cur_x_r;
  assign cur_y_nxt = (!x_major_r || dec_pos) ? (neg_y_r ? cur_y_r - CW'(1) : cur_y_r + CW'(1))
                                             : cur_y_r;
  assign dec_add   = $signed({3'b000, (x_major_r ? tdy_r : tdx_r)});
  assign dec_sub   = dec_pos ? $signed({3'b000, (x_major_r ? tdx_r : tdy_r)}) : '0;
  assign dec_nxt   = dec_r + dec_add - dec_sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (ctrl.load) begin
      active_r <= flags.accept;
    end else if (ctrl.step && active_r && at_end) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur_x_r   <= start_x;
      cur_y_r   <= start_y;
      stop_r    <= stop_coord;
      dec_r     <= decision;
      tdx_r     <= twice_dx;
      tdy_r     <= twice_dy;
      x_major_r <= flags.x_major;
      neg_x_r   <= flags.neg_x;
      neg_y_r   <= flags.neg_y;
      cx0_r     <= clip_x0;
      cx1_r     <= clip_x1;
      cy0_r     <= clip_y0;
      cy1_r     <= clip_y1;
    end else if (ctrl.step && active_r && !at_end) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      dec_r   <= dec_nxt;
    end
  end

endmodule
